FILE: design/tls_pkg.sv
package tls_pkg;

  // Port and field widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SLOPE_W    = 16;
  localparam int POS_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int DIR_W      = 16;
  localparam int BRIGHT_W   = 17;

  // Internal widths.
  localparam int SQ_IN_W   = 64;  // root pipe operand width
  localparam int SQ_LANES  = 2;   // normal length and anchor distance
  localparam int NLEN_W    = 21;  // normal length, Q16, below 2^21
  localparam int LLEN_W    = 16;  // light vector length, Q14
  localparam int NUM_W     = 34;  // signed dot product numerator, Q26
  localparam int N1_W      = 51;  // numerator shifted up by 20
  localparam int D1_W      = NLEN_W + LLEN_W;
  localparam int DEN_W     = 50;  // attenuation denominator, Q32
  localparam int B_W       = 33;  // brightness times strength, Q29
  localparam int N2_W      = B_W + 19;
  localparam int Q_BITS    = 16;  // quotient bits below the saturation bit

  // Constants.
  localparam logic [BRIGHT_W-1:0] ONE_Q16 = BRIGHT_W'(65536);
  localparam logic [GAIN_W-1:0] CG_MIN = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0] CG_MAX = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] ST_MAX = GAIN_W'(32768);
  localparam logic [14:0] ATTEN_K_Q24 = 15'd25166;
  localparam logic signed [DIR_W-1:0] FALLBACK_UX = -16'sd7373;
  localparam logic signed [DIR_W-1:0] FALLBACK_UY = -16'sd14418;

  // Register reset values.
  localparam logic [GAIN_W-1:0] RST_STRENGTH = GAIN_W'(8192);
  localparam logic [GAIN_W-1:0] RST_CONTRAST = GAIN_W'(8192);
  localparam logic signed [DIR_W-1:0] RST_DIR_X = -16'sd7373;
  localparam logic signed [DIR_W-1:0] RST_DIR_Y = -16'sd14418;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_EN = 3'd6;

  typedef struct packed {
    logic signed [DIR_W-1:0] ux;
    logic signed [DIR_W-1:0] uy;
    logic [LLEN_W-1:0]       llen;
  } light_vec_t;

  typedef enum logic [3:0] {
    CU_IDLE,
    CU_DSQ,
    CU_DROOT,
    CU_DXSET,
    CU_DIVX,
    CU_DYSET,
    CU_DIVY,
    CU_LSQ,
    CU_LROOT
  } dir_state_t;

endpackage

FILE: design/tls_if.sv
interface tls_sample_if import tls_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SLOPE_W-1:0] slope_x;
  logic signed [SLOPE_W-1:0] slope_y;
  logic signed [POS_W-1:0]   world_x;
  logic signed [POS_W-1:0]   world_y;

  modport source (output valid, slope_x, slope_y, world_x, world_y, input ready);
  modport sink (input valid, slope_x, slope_y, world_x, world_y, output ready);
endinterface

interface tls_shade_if import tls_pkg::*;;
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness;

  modport source (output valid, brightness, input ready);
  modport sink (input valid, brightness, output ready);
endinterface

FILE: design/tls_isqrt_pipe.sv
module tls_isqrt_pipe import tls_pkg::*; #(
  parameter int IN_W   = SQ_IN_W,
  parameter int LANES  = SQ_LANES,
  parameter int SIDE_W = NUM_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [IN_W-1:0]        x_in [LANES],
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic [IN_W/2-1:0]      root [LANES],
  output logic [SIDE_W-1:0]      side_out
);

  localparam int STAGES = IN_W / 2;

  logic              vld  [0:STAGES];
  logic [SIDE_W-1:0] side [0:STAGES];
  logic [IN_W-1:0]   xr   [0:STAGES][0:LANES-1];
  logic [IN_W-1:0]   rr   [0:STAGES][0:LANES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int l = 0; l < LANES; l++) begin
        xr[0][l] <= x_in[l];
        rr[0][l] <= '0;
      end
    end
  end

  // One result bit per stage, from the top.
  for (genvar j = 1; j <= STAGES; j++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 * j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [IN_W-1:0] trial;
      logic            ge;

      always_comb begin
        trial = rr[j-1][l] + BIT;
        ge    = xr[j-1][l] >= trial;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          xr[j][l] <= ge ? xr[j-1][l] - trial : xr[j-1][l];
          rr[j][l] <= ge ? (rr[j-1][l] >> 1) + BIT : rr[j-1][l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j] <= side[j-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = rr[STAGES][l][IN_W/2-1:0];
    end
  end

  assign out_valid = vld[STAGES];
  assign side_out  = side[STAGES];

endmodule

FILE: design/tls_div_pipe.sv
module tls_div_pipe import tls_pkg::*; #(
  parameter int N_W    = N1_W,
  parameter int D_W    = D1_W,
  parameter int SIDE_W = DEN_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [N_W-1:0]      num,
  input  logic [D_W-1:0]      den,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [BRIGHT_W-1:0] quo,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int Q_W = Q_BITS;
  localparam int CW  = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic              vld  [0:Q_W];
  logic              sat  [0:Q_W];
  logic [N_W-1:0]    rem  [0:Q_W];
  logic [D_W-1:0]    dd   [0:Q_W];
  logic [Q_W-1:0]    q    [0:Q_W];
  logic [SIDE_W-1:0] side [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // A quotient of 2^16 or more clamps to one; otherwise 16 bits remain.
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0]  <= CW'(num) >= (CW'(den) << Q_W);
      rem[0]  <= num;
      dd[0]   <= den;
      q[0]    <= '0;
      side[0] <= side_in;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    localparam int K = Q_W - i;
    logic [CW-1:0] cand;
    logic          ge;

    always_comb begin
      cand = CW'(dd[i-1]) << K;
      ge   = CW'(rem[i-1]) >= cand;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? N_W'(CW'(rem[i-1]) - cand) : rem[i-1];
        q[i]    <= ge ? (q[i-1] | (Q_W'(1) << K)) : q[i-1];
        sat[i]  <= sat[i-1];
        dd[i]   <= dd[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = sat[Q_W] ? ONE_Q16 : BRIGHT_W'(q[Q_W]);
  assign side_out  = side[Q_W];

endmodule

FILE: design/tls_dir_unit.sv
module tls_dir_unit import tls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  output light_vec_t              lvec,
  output logic                    busy
);

  dir_state_t state, state_next;
  logic [3:0]  cnt;
  logic [31:0] sq_x, sq_r;
  logic [15:0] dlen;
  logic [30:0] rem;
  logic [15:0] q;

  logic [31:0] sq_bit, sq_trial, sq_x_next, sq_r_next;
  logic        sq_ge;
  logic [30:0] cand, rem_next;
  logic [15:0] q_next;
  logic        div_ge;
  logic [15:0] mag_x, mag_y;
  logic        dir_zero;

  // Shared root step, then shared division step.
  always_comb begin
    sq_bit    = 32'(1) << {cnt, 1'b0};
    sq_trial  = sq_r + sq_bit;
    sq_ge     = sq_x >= sq_trial;
    sq_x_next = sq_ge ? sq_x - sq_trial : sq_x;
    sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;
    cand      = 31'(dlen) << cnt;
    div_ge    = rem >= cand;
    rem_next  = div_ge ? rem - cand : rem;
    q_next    = div_ge ? (q | (16'(1) << cnt)) : q;
    mag_x     = dir_x[DIR_W-1] ? 16'(-dir_x) : 16'(dir_x);
    mag_y     = dir_y[DIR_W-1] ? 16'(-dir_y) : 16'(dir_y);
    dir_zero  = (dir_x == '0) && (dir_y == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CU_IDLE:  state_next = CU_IDLE;
      CU_DSQ:   state_next = dir_zero ? CU_LSQ : CU_DROOT;
      CU_DROOT: if (cnt == '0) state_next = CU_DXSET;
      CU_DXSET: state_next = CU_DIVX;
      CU_DIVX:  if (cnt == '0) state_next = CU_DYSET;
      CU_DYSET: state_next = CU_DIVY;
      CU_DIVY:  if (cnt == '0) state_next = CU_LSQ;
      CU_LSQ:   state_next = CU_LROOT;
      CU_LROOT: if (cnt == '0) state_next = CU_IDLE;
      default:  state_next = CU_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != CU_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CU_DSQ;
    end else if (start) begin
      state <= CU_DSQ;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CU_DSQ: begin
        sq_x <= 32'(dir_x * dir_x) + 32'(dir_y * dir_y);
        sq_r <= '0;
        cnt  <= 4'd15;
        if (dir_zero) begin
          lvec.ux <= FALLBACK_UX;
          lvec.uy <= FALLBACK_UY;
        end
      end
      CU_DROOT, CU_LROOT: begin
        sq_x <= sq_x_next;
        sq_r <= sq_r_next;
        cnt  <= cnt - 4'd1;
        if (cnt == '0) begin
          if (state == CU_DROOT) begin
            dlen <= sq_r_next[15:0];
          end else begin
            lvec.llen <= sq_r_next[LLEN_W-1:0];
          end
        end
      end
      CU_DXSET, CU_DYSET: begin
        rem <= (31'(state == CU_DXSET ? mag_x : mag_y) << 14) + 31'(dlen >> 1);
        q   <= '0;
        cnt <= 4'd15;
      end
      CU_DIVX, CU_DIVY: begin
        rem <= rem_next;
        q   <= q_next;
        cnt <= cnt - 4'd1;
        if (cnt == '0) begin
          if (state == CU_DIVX) begin
            lvec.ux <= dir_x[DIR_W-1] ? -$signed(q_next) : $signed(q_next);
          end else begin
            lvec.uy <= dir_y[DIR_W-1] ? -$signed(q_next) : $signed(q_next);
          end
        end
      end
      CU_LSQ: begin
        sq_x <= 32'(lvec.ux * lvec.ux) + 32'(lvec.uy * lvec.uy) + (32'(1) << 28);
        sq_r <= '0;
        cnt  <= 4'd15;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/terrain_lambert_shade.sv
// Channel  Role    Handshake      Payload
// sample   sink    valid/ready    slope_x, slope_y (Q4.12), world_x, world_y (Q24.8)
// shade    source  valid/ready    brightness (Q1.16)
// cfg      write   cfg_we         cfg_index, cfg_wdata
//
// One sample enters per cycle while sample.ready is high.
// The depth comes mostly from the 32-stage square root pipe and two 17-stage dividers.
// After reset, and after every write to light_dir_x or light_dir_y, the light
// vector unit normalizes the direction serially (a zero direction takes the
// fallback vector and skips the division), during which sample.ready is low.
// A stalled shade output freezes the whole pipe; nothing is dropped or repeated.
module terrain_lambert_shade import tls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tls_sample_if.sink            sample,
  tls_shade_if.source           shade
);

  // Configuration registers.
  logic [GAIN_W-1:0]       strength_gain;
  logic [GAIN_W-1:0]       contrast_gain;
  logic signed [DIR_W-1:0] light_dir_x;
  logic signed [DIR_W-1:0] light_dir_y;
  logic signed [POS_W-1:0] anchor_x;
  logic signed [POS_W-1:0] anchor_y;
  logic                    anchor_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength_gain  <= RST_STRENGTH;
      contrast_gain  <= RST_CONTRAST;
      light_dir_x    <= RST_DIR_X;
      light_dir_y    <= RST_DIR_Y;
      anchor_x       <= '0;
      anchor_y       <= '0;
      anchor_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRENGTH:  strength_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_CONTRAST:  contrast_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_DIR_X:     light_dir_x    <= $signed(cfg_wdata[DIR_W-1:0]);
        REG_DIR_Y:     light_dir_y    <= $signed(cfg_wdata[DIR_W-1:0]);
        REG_ANCHOR_X:  anchor_x       <= $signed(cfg_wdata[POS_W-1:0]);
        REG_ANCHOR_Y:  anchor_y       <= $signed(cfg_wdata[POS_W-1:0]);
        REG_ANCHOR_EN: anchor_enable  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The unit light vector depends on configuration alone, so it is worked out
  // once per direction write by a small serial unit and held for the pipe.
  light_vec_t lv;
  logic       light_busy;
  logic       dir_write;

  assign dir_write = cfg_we && (cfg_index == REG_DIR_X || cfg_index == REG_DIR_Y);

  tls_dir_unit u_dir (
    .clk   (clk),
    .rst   (rst),
    .start (dir_write),
    .dir_x (light_dir_x),
    .dir_y (light_dir_y),
    .lvec  (lv),
    .busy  (light_busy)
  );

  // Clamped gains.
  logic [GAIN_W-1:0] cg, st;
  always_comb begin
    cg = contrast_gain;
    if (contrast_gain < CG_MIN) cg = CG_MIN;
    if (contrast_gain > CG_MAX) cg = CG_MAX;
    st = (strength_gain > ST_MAX) ? ST_MAX : strength_gain;
  end

  // The whole pipe advances together unless the output holds an untaken result.
  logic en, in_fire;
  logic div2_valid;

  assign en           = !div2_valid || shade.ready;
  assign sample.ready = en && !light_busy;
  assign in_fire      = sample.valid && sample.ready;

  // Stage 1: capture the sample.
  logic                      v1;
  logic signed [SLOPE_W-1:0] sx1, sy1;
  logic signed [POS_W-1:0]   wx1, wy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1 <= sample.slope_x;
      sy1 <= sample.slope_y;
      wx1 <= sample.world_x;
      wy1 <= sample.world_y;
    end
  end

  // Stage 2: slope squares, slope-light products and halved anchor offsets.
  logic                v2;
  logic [31:0]         psx2, psy2;
  logic signed [31:0]  pnx2, pny2;
  logic [30:0]         ex2, ey2;
  logic signed [POS_W:0] ddx, ddy;
  logic [POS_W:0]      mdx, mdy;

  always_comb begin
    ddx = (POS_W+1)'(wx1) - (POS_W+1)'(anchor_x);
    ddy = (POS_W+1)'(wy1) - (POS_W+1)'(anchor_y);
    mdx = ddx[POS_W] ? (POS_W+1)'(-ddx) : (POS_W+1)'(ddx);
    mdy = ddy[POS_W] ? (POS_W+1)'(-ddy) : (POS_W+1)'(ddy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psx2 <= 32'(sx1 * sx1);
      psy2 <= 32'(sy1 * sy1);
      pnx2 <= 32'(sx1 * lv.ux);
      pny2 <= 32'(sy1 * lv.uy);
      ex2  <= mdx[31:1];
      ey2  <= mdy[31:1];
    end
  end

  // Stage 3: squared normal length (Q32), dot numerator (Q26), offset squares.
  logic                    v3;
  logic [40:0]             nsq3;
  logic signed [NUM_W-1:0] num3;
  logic [61:0]             esx3, esy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsq3 <= (41'(psx2) + 41'(psy2) + (41'(1) << 24)) << 8;
      num3 <= (NUM_W'(1) << 26) - NUM_W'(pnx2) - NUM_W'(pny2);
      esx3 <= 62'(ex2) * 62'(ex2);
      esy3 <= 62'(ey2) * 62'(ey2);
    end
  end

  // Stage 4: squared anchor distance, from the halved offsets (a quarter of the square).
  logic                    v4;
  logic [40:0]             nsq4;
  logic signed [NUM_W-1:0] num4;
  logic [62:0]             esum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsq4  <= nsq3;
      num4  <= num3;
      esum4 <= 63'(esx3) + 63'(esy3);
    end
  end

  // Both square roots run side by side: normal length and anchor distance.
  logic [SQ_IN_W-1:0]   sq_in   [SQ_LANES];
  logic [SQ_IN_W/2-1:0] sq_root [SQ_LANES];
  logic                 vr;
  logic [NUM_W-1:0]     num_r;

  assign sq_in[0] = SQ_IN_W'(nsq4);
  assign sq_in[1] = SQ_IN_W'(esum4);

  tls_isqrt_pipe #(
    .IN_W   (SQ_IN_W),
    .LANES  (SQ_LANES),
    .SIDE_W (NUM_W)
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .x_in      (sq_in),
    .side_in   (num4),
    .out_valid (vr),
    .root      (sq_root),
    .side_out  (num_r)
  );

  // Stage 5: dot denominator, attenuation denominator and shifted numerator.
  // Without the anchor the denominator is exactly 2^32, which reduces the
  // final division to the plain shift by 13.
  logic              v5;
  logic [D1_W-1:0]   dn5;
  logic [DEN_W-1:0]  den5;
  logic [N1_W-1:0]   n1_5;
  logic [SQ_IN_W/2:0] adist;
  logic              num_pos;

  always_comb begin
    adist   = {sq_root[1], 1'b0};
    num_pos = !num_r[NUM_W-1] && (num_r != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn5  <= D1_W'(sq_root[0][NLEN_W-1:0]) * D1_W'(lv.llen);
      den5 <= anchor_enable
            ? (DEN_W'(1) << 32) + DEN_W'(DEN_W'(adist) * DEN_W'(ATTEN_K_Q24))
            : (DEN_W'(1) << 32);
      n1_5 <= num_pos ? (N1_W'(num_r[30:0]) << 20) : '0;
    end
  end

  // Cosine term, Q16, clamped to one.
  logic                vd1;
  logic [BRIGHT_W-1:0] ndotl;
  logic [DEN_W-1:0]    den_d1;

  tls_div_pipe #(
    .N_W    (N1_W),
    .D_W    (D1_W),
    .SIDE_W (DEN_W)
  ) u_div_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .num       (n1_5),
    .den       (dn5),
    .side_in   (den5),
    .out_valid (vd1),
    .quo       (ndotl),
    .side_out  (den_d1)
  );

  // Stage 6: contrast around mid grey, v = 2^28 + (ndotl - 0.5) * gain.
  logic               v6;
  logic signed [31:0] cv6;
  logic [DEN_W-1:0]   den6;
  logic signed [BRIGHT_W:0] cdiff;
  logic signed [BRIGHT_W+GAIN_W+1:0] cprod;

  always_comb begin
    cdiff = $signed({1'b0, ndotl}) - (BRIGHT_W+1)'(32768);
    cprod = cdiff * $signed({1'b0, cg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv6  <= 32'(cprod) + (32'sd1 <<< 28);
      den6 <= den_d1;
    end
  end

  // Stage 7: clamp the contrast result to [0,1] and apply strength.
  logic                v7;
  logic [B_W-1:0]      b7;
  logic [DEN_W-1:0]    den7;
  logic [BRIGHT_W-1:0] c6;
  logic [31:0]         cshift;

  always_comb begin
    cshift = 32'(cv6 >>> 13);
    if (cv6 <= 0) begin
      c6 = '0;
    end else if (cshift > 32'(ONE_Q16)) begin
      c6 = ONE_Q16;
    end else begin
      c6 = cshift[BRIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b7   <= B_W'(c6) * B_W'(st);
      den7 <= den6;
    end
  end

  // Attenuation and final clamp; the last divider stage is the output register.
  logic [DEN_W-1:0] den_unused;

  tls_div_pipe #(
    .N_W    (N2_W),
    .D_W    (DEN_W),
    .SIDE_W (DEN_W)
  ) u_div_atten (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .num       (N2_W'(b7) << 19),
    .den       (den7),
    .side_in   (den7),
    .out_valid (div2_valid),
    .quo       (shade.brightness),
    .side_out  (den_unused)
  );

  assign shade.valid = div2_valid;

  // No sample is taken while the light vector is being recomputed.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    light_busy |-> !sample.ready)
    else $error("sample taken while light vector unit is busy");

  // A held result stalls the input side too.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (shade.valid && !shade.ready) |-> !sample.ready)
    else $error("sample taken while output is stalled");

  // Brightness never exceeds one.
  a_bright_range: assert property (@(posedge clk) disable iff (rst)
    shade.valid |-> (shade.brightness <= ONE_Q16))
    else $error("brightness above one");

endmodule
